FILE: hdl/mrem_pkg.sv
// Shared types and constants for the masked row effect mean block.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package mrem_pkg;

    // Width of one input value (Q16.16) and of one effect or mean (Q17.16).
    localparam int unsigned IN_W  = 32;
    localparam int unsigned EFF_W = 33;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // cell transfer: form effect, accumulate, load divider on row end
        logic step;    // one quotient bit
        logic finish;  // sign the quotient into the pending result
        logic move;    // pending result into the output register
    } t_mrem_cmd;

endpackage

`default_nettype wire

FILE: hdl/mrem_datapath.sv
// Datapath: effect subtractor, row accumulator, bit-serial divider,
// pending result stage and output register. Depends on mrem_pkg.
`default_nettype none

module mrem_datapath #(
    parameter int unsigned ROW_CELLS_MAX = 256,
    parameter int unsigned CNT_W         = 9,
    parameter int unsigned SUM_W         = 41
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire mrem_pkg::t_mrem_cmd               i_cmd,
    input  wire logic signed [mrem_pkg::IN_W-1:0]  i_outcome,
    input  wire logic signed [mrem_pkg::IN_W-1:0]  i_counterfactual,
    input  wire logic                              i_treated,
    input  wire logic                              i_observed,
    input  wire logic                              i_row_end,
    output logic signed [mrem_pkg::EFF_W-1:0]      o_effect,
    output logic                                   o_effect_valid,
    output logic signed [mrem_pkg::EFF_W-1:0]      o_row_mean,
    output logic                                   o_row_mean_valid,
    output logic [CNT_W-1:0]                       o_row_count,
    output logic                                   o_row_done
);

    localparam logic [CNT_W-1:0] MAX_C = CNT_W'(ROW_CELLS_MAX);

    // row state
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0]        r_cnt, n_cnt;

    // divider
    logic [SUM_W-1:0] r_q;
    logic [CNT_W-1:0] r_r;
    logic [CNT_W-1:0] r_d;
    logic             r_neg;

    // pending result
    logic signed [mrem_pkg::EFF_W-1:0] r_p_effect;
    logic                              r_p_effect_valid;
    logic signed [mrem_pkg::EFF_W-1:0] r_p_row_mean;
    logic                              r_p_row_mean_valid;
    logic [CNT_W-1:0]                  r_p_row_count;
    logic                              r_p_row_done;

    logic signed [mrem_pkg::EFF_W-1:0] eff;
    logic                              cell_ok;
    logic                              add;
    logic [SUM_W-1:0]                  mag;
    logic [CNT_W:0]                    rem_sh;
    logic [CNT_W:0]                    rem_sub;
    logic                              ge;
    logic [mrem_pkg::EFF_W-1:0]        qm;
    logic signed [mrem_pkg::EFF_W-1:0] mean;

    always_comb begin
        eff     = mrem_pkg::EFF_W'(i_outcome) - mrem_pkg::EFF_W'(i_counterfactual);
        cell_ok = i_treated & i_observed;
        add     = cell_ok && (r_cnt < MAX_C);
        n_sum   = r_sum + (add ? SUM_W'(eff) : '0);
        n_cnt   = r_cnt + CNT_W'(add);
        mag     = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
        rem_sh  = {r_r, r_q[SUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_d};
        ge      = rem_sh >= {1'b0, r_d};
        qm      = r_q[mrem_pkg::EFF_W-1:0];
        mean    = r_neg ? $signed(-qm) : $signed(qm);
    end

    // accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_cnt <= '0;
        end else if (i_cmd.load) begin
            if (i_row_end) begin
                r_sum <= '0;
                r_cnt <= '0;
            end else begin
                r_sum <= n_sum;
                r_cnt <= n_cnt;
            end
        end
    end

    // divider, pending stage and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_p_effect       <= cell_ok ? eff : '0;
            r_p_effect_valid <= cell_ok;
            r_p_row_mean     <= '0;
            r_p_row_done     <= i_row_end;
            if (i_row_end) begin
                r_q                <= mag;
                r_r                <= '0;
                r_d                <= n_cnt;
                r_neg              <= n_sum[SUM_W-1];
                r_p_row_count      <= n_cnt;
                r_p_row_mean_valid <= (n_cnt != '0);
            end else begin
                r_p_row_count      <= '0;
                r_p_row_mean_valid <= 1'b0;
            end
        end
        if (i_cmd.step) begin
            r_r <= ge ? rem_sub[CNT_W-1:0] : rem_sh[CNT_W-1:0];
            r_q <= {r_q[SUM_W-2:0], ge};
        end
        if (i_cmd.finish) begin
            r_p_row_mean <= r_p_row_mean_valid ? mean : '0;
        end
        if (i_cmd.move) begin
            o_effect         <= r_p_effect;
            o_effect_valid   <= r_p_effect_valid;
            o_row_mean       <= r_p_row_mean;
            o_row_mean_valid <= r_p_row_mean_valid;
            o_row_count      <= r_p_row_count;
            o_row_done       <= r_p_row_done;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/mrem_ctrl.sv
// Controller: handshakes, pending/output occupancy and divider sequencing.
// Depends on mrem_pkg; drives the datapath commands.
`default_nettype none

module mrem_ctrl #(
    parameter int unsigned SUM_W = 41
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic          i_row_end,
    output logic               o_valid,
    input  wire logic          i_ready,
    output mrem_pkg::t_mrem_cmd o_cmd
);

    localparam int unsigned STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_FIN
    } t_state;

    t_state            r_state;
    logic [STEP_W-1:0] r_step;
    logic              r_pend_full;
    logic              r_out_full;

    logic in_xfer, out_xfer, move;

    always_comb begin
        out_xfer    = r_out_full & i_ready;
        move        = (r_state == ST_IDLE) && r_pend_full && (!r_out_full || out_xfer);
        o_ready     = (r_state == ST_IDLE) && (!r_pend_full || move);
        in_xfer     = i_valid & o_ready;
        o_valid     = r_out_full;
        o_cmd.load   = in_xfer;
        o_cmd.step   = (r_state == ST_DIV);
        o_cmd.finish = (r_state == ST_FIN);
        o_cmd.move   = move;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_step      <= '0;
            r_pend_full <= 1'b0;
            r_out_full  <= 1'b0;
        end else begin
            if (move) begin
                r_out_full <= 1'b1;
            end else if (out_xfer) begin
                r_out_full <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        r_pend_full <= 1'b1;
                        r_step      <= '0;
                        if (i_row_end) begin
                            r_state <= ST_DIV;
                        end
                    end else if (move) begin
                        r_pend_full <= 1'b0;
                    end
                end
                ST_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_state <= ST_FIN;
                    end
                end
                ST_FIN: begin
                    r_state <= ST_IDLE;
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_busy_no_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> !o_ready)
        else $error("input ready while divider busy");
    a_div_has_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_IDLE) |-> r_pend_full)
        else $error("divider running without a pending row result");
    a_move_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        move |=> r_out_full)
        else $error("output register empty after move");
    a_fin_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN) |=> (r_state == ST_IDLE))
        else $error("finish state held");
`endif

endmodule

`default_nettype wire

FILE: hdl/masked_row_effect_mean.sv
// Top level of the masked row effect mean block.
// Instantiates mrem_ctrl and mrem_datapath; depends on mrem_pkg.
`default_nettype none

// Cells of a panel stream in row order, one transfer per cell, and each cell
// gives exactly one result transfer. A cell that is both treated and observed
// gives effect = outcome - counterfactual (33-bit signed Q17.16) with
// effect_valid set; any other cell gives a zero effect with effect_valid
// clear. Valid effects add into a row sum and count; the count saturates at
// ROW_CELLS_MAX, after which further valid effects are reported but not
// summed. The cell flagged row_end closes the row: its result also carries
// row_done, the count and the mean (sum / count, truncated toward zero), with
// row_mean_valid clear and a zero mean when the row had no valid effect.
// Cells that do not end a row stream back to back while the result channel
// keeps taking results. A row-end cell holds off further input while the
// restoring divider produces one quotient bit a cycle over the SUM_W-bit sum
// magnitude, after which a finish step signs the quotient. A pending stage ahead
// of the output register lets the next cell transfer in while a finished
// result still waits downstream.
// Reset is synchronous, active low, and clears the row sum and count.
module masked_row_effect_mean #(
    parameter int unsigned ROW_CELLS_MAX = 256,
    localparam int unsigned CNT_W = $clog2(ROW_CELLS_MAX + 1),
    localparam int unsigned SUM_W = mrem_pkg::EFF_W +
                                    ((ROW_CELLS_MAX > 1) ? $clog2(ROW_CELLS_MAX) : 0)
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // cell channel
    input  wire logic                              i_valid,
    output logic                                   o_ready,
    input  wire logic signed [mrem_pkg::IN_W-1:0]  i_outcome,
    input  wire logic signed [mrem_pkg::IN_W-1:0]  i_counterfactual,
    input  wire logic                              i_treated,
    input  wire logic                              i_observed,
    input  wire logic                              i_row_end,
    // result channel
    output logic                                   o_valid,
    input  wire logic                              i_ready,
    output logic signed [mrem_pkg::EFF_W-1:0]      o_effect,
    output logic                                   o_effect_valid,
    output logic signed [mrem_pkg::EFF_W-1:0]      o_row_mean,
    output logic                                   o_row_mean_valid,
    output logic [CNT_W-1:0]                       o_row_count,
    output logic                                   o_row_done
);

    // controller -> datapath commands
    mrem_pkg::t_mrem_cmd cmd;

    // sequencing: handshakes, occupancy of pending and output stages, divider steps
    mrem_ctrl #(
        .SUM_W (SUM_W)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_row_end (i_row_end),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_cmd     (cmd)
    );

    // arithmetic: subtractor, accumulator, divider, result registers
    mrem_datapath #(
        .ROW_CELLS_MAX (ROW_CELLS_MAX),
        .CNT_W         (CNT_W),
        .SUM_W         (SUM_W)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_outcome        (i_outcome),
        .i_counterfactual (i_counterfactual),
        .i_treated        (i_treated),
        .i_observed       (i_observed),
        .i_row_end        (i_row_end),
        .o_effect         (o_effect),
        .o_effect_valid   (o_effect_valid),
        .o_row_mean       (o_row_mean),
        .o_row_mean_valid (o_row_mean_valid),
        .o_row_count      (o_row_count),
        .o_row_done       (o_row_done)
    );

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for masked_row_effect_mean: a queue-fed cell driver,
// a result monitor and an in-bench row-mean predictor.
// Depends on mrem_pkg and the masked_row_effect_mean RTL.

module tb_top;

    localparam int unsigned ROW_MAX        = 256;
    localparam int unsigned CNT_W          = $clog2(ROW_MAX + 1);
    // Tail wait after the last phase; it covers a couple of row-end cells.
    localparam int unsigned DRAIN_CYCLES   = 100;
    localparam int unsigned HOLD_CYCLES    = 300;
    localparam int unsigned PHASE_CELLS    = 70;
    localparam int unsigned POS_ROW_LEN    = 32;
    localparam int unsigned REPORT_MAX     = 10;
    localparam int unsigned TIMEOUT_CYCLES = 400000;

    typedef struct {
        logic signed [mrem_pkg::IN_W-1:0] outcome;
        logic signed [mrem_pkg::IN_W-1:0] counterfactual;
        logic                             treated;
        logic                             observed;
        logic                             row_end;
    } t_cell;

    typedef struct {
        logic signed [mrem_pkg::EFF_W-1:0] effect;
        logic                              effect_valid;
        logic signed [mrem_pkg::EFF_W-1:0] row_mean;
        logic                              row_mean_valid;
        logic [CNT_W-1:0]                  row_count;
        logic                              row_done;
    } t_cell_result;

    // ------------------------------------------------------------------
    // DUT signals; the inputs are known from time zero
    // ------------------------------------------------------------------
    logic                              i_clk            = 1'b0;
    logic                              i_rst_n          = 1'b0;
    logic                              i_valid          = 1'b0;
    logic                              o_ready;
    logic signed [mrem_pkg::IN_W-1:0]  i_outcome        = '0;
    logic signed [mrem_pkg::IN_W-1:0]  i_counterfactual = '0;
    logic                              i_treated        = 1'b0;
    logic                              i_observed       = 1'b0;
    logic                              i_row_end        = 1'b0;
    logic                              o_valid;
    logic                              i_ready          = 1'b0;
    logic signed [mrem_pkg::EFF_W-1:0] o_effect;
    logic                              o_effect_valid;
    logic signed [mrem_pkg::EFF_W-1:0] o_row_mean;
    logic                              o_row_mean_valid;
    logic [CNT_W-1:0]                  o_row_count;
    logic                              o_row_done;

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    t_cell        pending_cells[$];     // cells waiting to be offered
    t_cell        offered_cell;         // cell currently on the input port
    t_cell_result expected_results[$];  // predicted results, oldest first
    t_cell_result oldest_expected;

    // predictor's own copy of the row accumulator
    longint      acc_sum  = 0;
    int unsigned acc_cnt  = 0;
    logic        acc_sat  = 1'b0;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_off       = 1'b0;

    int unsigned cycle_count    = 0;
    int unsigned cells_sent     = 0;
    int unsigned results_seen   = 0;
    int unsigned rows_closed    = 0;
    int unsigned empty_rows     = 0;
    int unsigned saturated_rows = 0;
    int unsigned mismatch_count = 0;

    masked_row_effect_mean #(
        .ROW_CELLS_MAX(ROW_MAX)
    ) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_outcome        (i_outcome),
        .i_counterfactual (i_counterfactual),
        .i_treated        (i_treated),
        .i_observed       (i_observed),
        .i_row_end        (i_row_end),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_effect         (o_effect),
        .o_effect_valid   (o_effect_valid),
        .o_row_mean       (o_row_mean),
        .o_row_mean_valid (o_row_mean_valid),
        .o_row_count      (o_row_count),
        .o_row_done       (o_row_done)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Row-mean predictor: effect per cell, saturating count, mean on row end.
    // SystemVerilog signed division truncates toward zero, as the block must.
    // ------------------------------------------------------------------
    function automatic t_cell_result predict_cell(t_cell c);
        t_cell_result r;
        longint       diff;
        longint       quot;
        logic         cell_ok;
        diff    = longint'(c.outcome) - longint'(c.counterfactual);
        cell_ok = c.treated && c.observed;
        quot    = 0;

        r.effect         = cell_ok ? diff[mrem_pkg::EFF_W-1:0] : '0;
        r.effect_valid   = cell_ok;
        r.row_mean       = '0;
        r.row_mean_valid = 1'b0;
        r.row_count      = '0;
        r.row_done       = c.row_end;

        if (cell_ok) begin
            if (acc_cnt < ROW_MAX) begin
                acc_sum = acc_sum + diff;
                acc_cnt = acc_cnt + 1;
            end else begin
                acc_sat = 1'b1;   // reported, but no longer summed
            end
        end

        if (c.row_end) begin
            r.row_count = acc_cnt[CNT_W-1:0];
            if (acc_cnt != 0) begin
                quot             = acc_sum / longint'(acc_cnt);
                r.row_mean       = quot[mrem_pkg::EFF_W-1:0];
                r.row_mean_valid = 1'b1;
            end else begin
                empty_rows++;
            end
            if (acc_sat) saturated_rows++;
            rows_closed++;
            acc_sum = 0;
            acc_cnt = 0;
            acc_sat = 1'b0;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Driver: offers queued cells; valid holds with a steady payload until
    // the transfer. The prediction is made at the transfer edge.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                expected_results.push_back(predict_cell(offered_cell));
                cells_sent++;
            end
            // free to load: nothing on the port, or it transfers this edge
            if (!i_valid || o_ready) begin
                if (pending_cells.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_cell      = pending_cells.pop_front();
                    i_outcome        <= offered_cell.outcome;
                    i_counterfactual <= offered_cell.counterfactual;
                    i_treated        <= offered_cell.treated;
                    i_observed       <= offered_cell.observed;
                    i_row_end        <= offered_cell.row_end;
                    i_valid          <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver back-pressure: random stalls, plus the long hold-off window.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
            $display("%0t ns: %s", $time, what);
        end
    endtask

    // ------------------------------------------------------------------
    // Monitor: every result transfer against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                note_mismatch($sformatf(
                    "result with none expected: eff=%0d/%b mean=%0d/%b cnt=%0d done=%b",
                    o_effect, o_effect_valid, o_row_mean, o_row_mean_valid,
                    o_row_count, o_row_done));
            end else begin
                oldest_expected = expected_results.pop_front();
                if (o_effect         !== oldest_expected.effect         ||
                    o_effect_valid   !== oldest_expected.effect_valid   ||
                    o_row_mean       !== oldest_expected.row_mean       ||
                    o_row_mean_valid !== oldest_expected.row_mean_valid ||
                    o_row_count      !== oldest_expected.row_count      ||
                    o_row_done       !== oldest_expected.row_done) begin
                    note_mismatch($sformatf({
                        "result %0d: exp eff=%0d/%b mean=%0d/%b cnt=%0d done=%b, ",
                        "got eff=%0d/%b mean=%0d/%b cnt=%0d done=%b"},
                        results_seen,
                        oldest_expected.effect, oldest_expected.effect_valid,
                        oldest_expected.row_mean, oldest_expected.row_mean_valid,
                        oldest_expected.row_count, oldest_expected.row_done,
                        o_effect, o_effect_valid, o_row_mean, o_row_mean_valid,
                        o_row_count, o_row_done));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic push_cell(logic signed [mrem_pkg::IN_W-1:0] outc,
                             logic signed [mrem_pkg::IN_W-1:0] cf,
                             logic tr, logic ob, logic last);
        t_cell c;
        c.outcome        = outc;
        c.counterfactual = cf;
        c.treated        = tr;
        c.observed       = ob;
        c.row_end        = last;
        pending_cells.push_back(c);
    endtask

    // mostly full-range values, with extremes and small ones mixed in so that
    // truncation of small negative sums gets exercised
    function automatic logic signed [mrem_pkg::IN_W-1:0] rand_value();
        case ($urandom_range(11))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            4, 5:    return $signed($urandom_range(2047)) - 1024;
            default: return $urandom;
        endcase
    endfunction

    // One row, every cell valid, with the same effect; longer than ROW_MAX
    // it drives the count into saturation.
    task automatic push_uniform_row(logic signed [mrem_pkg::IN_W-1:0] outc,
                                    logic signed [mrem_pkg::IN_W-1:0] cf,
                                    int unsigned len);
        for (int unsigned k = 0; k < len; k++) begin
            push_cell(outc, cf, 1'b1, 1'b1, k == len - 1);
        end
    endtask

    // Well-formed rows with random content; about one row in ten is noise
    // with random flags, row_end included, so rows break at odd places.
    task automatic push_random_rows(int unsigned n_cells);
        int unsigned pushed;
        int unsigned len;
        logic        noisy;
        logic        tr;
        logic        ob;
        logic        last;
        logic [1:0]  miss;
        pushed = 0;
        while (pushed < n_cells) begin
            len   = ($urandom_range(9) == 0) ? $urandom_range(40, 9) : $urandom_range(8, 1);
            noisy = ($urandom_range(9) == 0);
            for (int unsigned k = 0; k < len; k++) begin
                if (noisy) begin
                    tr   = 1'($urandom);
                    ob   = 1'($urandom);
                    last = 1'($urandom);
                end else begin
                    if ($urandom_range(9) < 7) begin
                        tr = 1'b1;
                        ob = 1'b1;
                    end else begin
                        miss = 2'($urandom_range(2));   // 00, 01 or 10
                        tr   = miss[1];
                        ob   = miss[0];
                    end
                    last = (k == len - 1);
                end
                push_cell(rand_value(), rand_value(), tr, ob, last);
            end
            pushed += len;
        end
    endtask

    // sender pauses here until every predicted result has been seen
    task automatic wait_drained();
        while (pending_cells.size() != 0 || i_valid || expected_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic run_phase(int unsigned send_pct, int unsigned recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        push_random_rows(PHASE_CELLS);
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // Long receiver hold-off early in the run, while cells keep coming,
    // so the pending stage fills and the input channel stalls.
    // ------------------------------------------------------------------
    initial begin
        @(posedge i_rst_n);
        repeat (30) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    initial begin
        while (cycle_count < TIMEOUT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycle_count, expected_results.size());
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed cells, no idling
        // single-cell rows at the effect extremes and zero
        push_cell(32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1, 1'b1, 1'b1);
        push_cell(32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1, 1'b1, 1'b1);
        push_cell(32'sh8000_0000, 32'sh0000_0000, 1'b1, 1'b1, 1'b1);
        push_cell('0, '0, 1'b1, 1'b1, 1'b1);
        // empty row: unobserved cell with nonzero values closes it
        push_cell(32'sh1234_5678, 32'sh0000_0001, 1'b1, 1'b0, 1'b1);
        // invalid cells of every kind leave the row alone, then one valid end
        push_cell(32'sh7FFF_FFFF, '0, 1'b0, 1'b1, 1'b0);
        push_cell('1, 32'sh0000_0005, 1'b0, 1'b0, 1'b0);
        push_cell(32'sh0000_0100, '0, 1'b1, 1'b0, 1'b0);
        push_cell(32'sh0000_0007, '0, 1'b1, 1'b1, 1'b1);
        // truncation toward zero, negative then positive
        push_cell(-32'sd7, '0, 1'b1, 1'b1, 1'b0);
        push_cell('0, '0, 1'b1, 1'b1, 1'b1);
        push_cell(32'sd7, '0, 1'b1, 1'b1, 1'b0);
        push_cell('0, '0, 1'b1, 1'b1, 1'b1);
        // small negative sum over three cells: valid mean of zero
        push_cell(32'sd1, '0, 1'b1, 1'b1, 1'b0);
        push_cell(32'sd1, '0, 1'b1, 1'b1, 1'b0);
        push_cell('0, 32'sd3, 1'b1, 1'b1, 1'b1);
        // row closed by an invalid cell after valid ones
        push_cell(32'sh0001_0000, '0, 1'b1, 1'b1, 1'b0);
        push_cell(32'sh0003_0000, '0, 1'b1, 1'b1, 1'b0);
        push_cell(32'sd99, 32'sd99, 1'b0, 1'b1, 1'b1);
        // valid cell with equal values gives a valid zero effect
        push_cell(32'sh5555_AAAA, 32'sh5555_AAAA, 1'b1, 1'b1, 1'b1);
        wait_drained();

        // count saturation at the negative extreme of the sum, a long row at
        // the positive extreme, then random rows
        push_uniform_row(32'sh8000_0000, 32'sh7FFF_FFFF, ROW_MAX + 2);
        push_uniform_row(32'sh7FFF_FFFF, 32'sh8000_0000, POS_ROW_LEN);
        run_phase(0, 0);

        run_phase(61, 0);
        run_phase(0, 61);
        run_phase(33, 33);

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (expected_results.size() != 0) begin
            note_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end

        $display("covered %0d cells, %0d rows (%0d empty, %0d saturated), %0d results",
                 cells_sent, rows_closed, empty_rows, saturated_rows, results_seen);
        $display("idle mixes: none, sender 61%%, receiver 61%%, both 33%%; %0d mismatches",
                 mismatch_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
